FILE: rtl/core/rau_pkg.sv
// Package for the rational arithmetic unit: widths, item structs, codes.
// No dependencies.
package rau_pkg;
  localparam int WIDTH = 32;
  localparam int WW    = 2 * WIDTH;
  localparam int CW    = $clog2(WW + 1);

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_OVFL  = 2'd2;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [WIDTH-1:0] a_num;
    logic [WIDTH-2:0]        a_den;
    logic signed [WIDTH-1:0] b_num;
    logic [WIDTH-2:0]        b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] res_num;
    logic [WIDTH-2:0]        res_den;
    logic [1:0]              status;
  } out_item_t;
endpackage

FILE: rtl/core/rau_alu.sv
// Shared datapath unit: one add, subtract or compare on double-width words.
// Depends on rau_pkg.
module rau_alu (
  input  logic [rau_pkg::WW-1:0] x,
  input  logic [rau_pkg::WW-1:0] y,
  input  logic                   sub,
  output logic [rau_pkg::WW:0]   sum,
  output logic                   x_ge_y
);
  assign sum    = sub ? ({1'b0, x} - {1'b0, y}) : ({1'b0, x} + {1'b0, y});
  assign x_ge_y = x >= y;
endmodule

FILE: rtl/core/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer around one shared ALU.
// Depends on rau_pkg and rau_alu.
//
// One item is taken at a time. Multiplies run shift-and-add, two for a product
// and three for a sum, difference or quotient. The binary GCD then works in
// shift and subtract steps on the double-width numerator and denominator, and
// each is divided by the GCD with a restoring division. All of this goes
// through the single adder of rau_alu. Error inputs go from the multiply state
// straight to the output state. The result waits in an output register, and no
// new item is taken until it has been accepted.
module rational_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rau_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rau_pkg::out_item_t out_data
);
  localparam int W  = rau_pkg::WIDTH;
  localparam int WW = rau_pkg::WW;
  localparam int CW = rau_pkg::CW;

  localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_COMB = 4'd2, S_GCD2 = 4'd3,
    S_GCDU = 4'd4, S_GCDV = 4'd5, S_GCDS = 4'd6, S_GSHL = 4'd7, S_DIVN = 4'd8,
    S_DIVD = 4'd9, S_CHK = 4'd10, S_OUT = 4'd11;

  logic [3:0] st_r, st_nxt;
  logic [1:0] mode_r;
  logic [W-1:0] am_r, bm_r;
  logic [W-2:0] ad_r, bd_r;
  logic an_r, bn_r, neg_r;
  logic [1:0] mi_r;                // multiply index: 0 am*bd (am*bm for MUL), 1 bm*ad, 2 ad*bd (ad*bm for DIV)
  logic [WW-1:0] acc_r, mc_r, mp_r;
  logic [WW-1:0] x_r, y_r, num_r, den_r, u_r, v_r, q_r, rem_r;
  logic [CW-1:0] cnt_r, k_r;
  logic         ov_r;
  rau_pkg::out_item_t out_r;

  logic [WW-1:0] ax, ay;
  logic          asub;
  logic [WW:0]   asum;
  logic          age;

  rau_alu u_alu (.x(ax), .y(ay), .sub(asub), .sum(asum), .x_ge_y(age));

  logic [WW:0] rsh;
  assign rsh = {rem_r, (st_r == S_DIVN) ? num_r[WW-1] : den_r[WW-1]};

  always_comb begin
    ax = acc_r; ay = mc_r; asub = 1'b0;
    unique case (st_r)
      S_COMB: begin
        if (mode_r[1]) begin ax = x_r; ay = '0; end
        else if (an_r == (bn_r ^ mode_r[0])) begin ax = x_r; ay = y_r; end
        else begin
          asub = 1'b1;
          if (x_r >= y_r) begin ax = x_r; ay = y_r; end
          else begin ax = y_r; ay = x_r; end
        end
      end
      S_GCDS: begin
        asub = 1'b1;
        if (u_r > v_r) begin ax = u_r; ay = v_r; end
        else begin ax = v_r; ay = u_r; end
      end
      S_DIVN, S_DIVD: begin ax = rsh[WW-1:0]; ay = u_r; asub = 1'b1; end
      default: begin ax = acc_r; ay = mc_r; asub = 1'b0; end
    endcase
  end

  logic [W-1:0] an_mag, bn_mag;
  assign an_mag = in_data.a_num[W-1] ? -in_data.a_num : in_data.a_num;
  assign bn_mag = in_data.b_num[W-1] ? -in_data.b_num : in_data.b_num;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (in_valid && !out_valid) st_nxt = S_MUL;
      S_MUL:   if (ov_r) st_nxt = S_OUT;
               else if (cnt_r == CW'(W - 1) && mi_r == 2'd2) st_nxt = S_COMB;
      S_COMB:  st_nxt = S_GCD2;
      S_GCD2:  if (num_r == '0) st_nxt = S_OUT;
               else if (u_r[0] || v_r[0]) st_nxt = S_GCDU;
      S_GCDU:  if (u_r[0]) st_nxt = S_GCDV;
      S_GCDV:  if (v_r[0]) st_nxt = S_GCDS;
      S_GCDS:  if (u_r == v_r) st_nxt = S_GSHL;
               else st_nxt = S_GCDV;
      S_GSHL:  if (k_r == '0) st_nxt = S_DIVN;
      S_DIVN:  if (cnt_r == CW'(WW - 1)) st_nxt = S_DIVD;
      S_DIVD:  if (cnt_r == CW'(WW - 1)) st_nxt = S_CHK;
      S_CHK:   st_nxt = S_OUT;
      S_OUT:   st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (st_r == S_OUT) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: if (!out_valid) begin
        mode_r <= in_data.mode;
        an_r <= in_data.a_num[W-1]; bn_r <= in_data.b_num[W-1];
        am_r <= an_mag; bm_r <= bn_mag;
        ad_r <= in_data.a_den; bd_r <= in_data.b_den;
        ov_r <= (in_data.a_den == '0) || (in_data.b_den == '0) ||
                (in_data.mode == rau_pkg::MODE_DIV && in_data.b_num == '0);
        out_r <= '{res_num: '0, res_den: (W-1)'(1), status: rau_pkg::ST_ZERO};
        mi_r <= 2'd0; cnt_r <= '0; acc_r <= '0;
        mc_r <= WW'(an_mag);
        mp_r <= (in_data.mode == rau_pkg::MODE_MUL) ? WW'(bn_mag) : WW'(in_data.b_den);
      end
      S_MUL: begin
        if (mp_r[0]) acc_r <= asum[WW-1:0];
        mc_r <= mc_r << 1; mp_r <= mp_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          cnt_r <= '0; mi_r <= mi_r + 1'b1; acc_r <= '0;
          unique case (mi_r)
            2'd0: begin
              x_r <= mp_r[0] ? asum[WW-1:0] : acc_r;
              if (mode_r == rau_pkg::MODE_MUL) begin
                mi_r <= 2'd2; mc_r <= WW'(ad_r); mp_r <= WW'(bd_r);
              end else begin
                mc_r <= WW'(bm_r); mp_r <= WW'(ad_r);
              end
            end
            2'd1: begin
              y_r <= mp_r[0] ? asum[WW-1:0] : acc_r;
              mc_r <= WW'(ad_r);
              mp_r <= (mode_r == rau_pkg::MODE_DIV) ? WW'(bm_r) : WW'(bd_r);
            end
            default: den_r <= mp_r[0] ? asum[WW-1:0] : acc_r;
          endcase
        end
      end
      S_COMB: begin
        num_r <= asum[WW-1:0]; u_r <= asum[WW-1:0]; v_r <= den_r; k_r <= '0;
        if (mode_r[1]) neg_r <= an_r ^ bn_r;
        else if (an_r == (bn_r ^ mode_r[0])) neg_r <= an_r;
        else neg_r <= (x_r >= y_r) ? an_r : (bn_r ^ mode_r[0]);
        out_r <= '{res_num: '0, res_den: (W-1)'(1), status: rau_pkg::ST_OK};
      end
      S_GCD2: if (!(u_r[0] || v_r[0])) begin
        u_r <= u_r >> 1; v_r <= v_r >> 1; k_r <= k_r + 1'b1;
      end
      S_GCDU: if (!u_r[0]) u_r <= u_r >> 1;
      S_GCDV: if (!v_r[0]) v_r <= v_r >> 1;
      S_GCDS: begin
        if (u_r > v_r) u_r <= v_r;
        v_r <= asum[WW-1:0];
      end
      S_GSHL: begin
        if (k_r != '0) begin u_r <= u_r << 1; k_r <= k_r - 1'b1; end
        cnt_r <= '0; rem_r <= '0;
      end
      S_DIVN, S_DIVD: begin
        if (st_r == S_DIVN) num_r <= {num_r[WW-2:0], 1'b0};
        else den_r <= {den_r[WW-2:0], 1'b0};
        if (rsh[WW] || age) begin
          rem_r <= asum[WW-1:0]; q_r <= {q_r[WW-2:0], 1'b1};
        end else begin
          rem_r <= rsh[WW-1:0]; q_r <= {q_r[WW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(WW - 1)) begin
          cnt_r <= '0; rem_r <= '0;
          if (st_r == S_DIVN) x_r <= {q_r[WW-2:0], (rsh[WW] || age)};
        end
      end
      S_CHK: begin
        if (q_r > WW'({(W-1){1'b1}}) ||
            x_r > (neg_r ? WW'({1'b1, {(W-1){1'b0}}}) : WW'({(W-1){1'b1}})))
          out_r <= '{res_num: '0, res_den: (W-1)'(1), status: rau_pkg::ST_OVFL};
        else
          out_r <= '{res_num: neg_r ? -x_r[W-1:0] : x_r[W-1:0],
                     res_den: q_r[W-2:0], status: rau_pkg::ST_OK};
      end
      default: ;
    endcase
  end

  assign in_ready = (st_r == S_IDLE) && !out_valid;
  assign out_data = out_r;

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_r.res_den != '0) else $error("zero result denominator");
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_r.status != rau_pkg::ST_OK) |->
    (out_r.res_num == '0 && out_r.res_den == (W-1)'(1))) else $error("bad error item");
endmodule

FILE: bench/tb_rational_arithmetic_unit.sv
// Testbench for the rational arithmetic unit: drives random and directed fraction items,
// predicts each reduced result and checks it in order against the block's outputs.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  function automatic out_item_t reduce_fraction(in_item_t it);
    out_item_t r;
    logic [127:0] am, bm, ad, bd, x, y, num, den, u, v, t;
    logic an, bn, yn, neg;
    r.res_num = '0;
    r.res_den = (WIDTH-1)'(1);
    r.status = ST_ZERO;
    an = it.a_num[WIDTH-1];
    bn = it.b_num[WIDTH-1];
    am = an ? 128'(-65'(signed'(it.a_num))) : 128'(it.a_num);
    bm = bn ? 128'(-65'(signed'(it.b_num))) : 128'(it.b_num);
    ad = 128'(it.a_den);
    bd = 128'(it.b_den);
    if (ad == 0 || bd == 0 || (it.mode == MODE_DIV && bm == 0)) return r;
    r.status = ST_OK;
    case (it.mode)
      MODE_ADD, MODE_SUB: begin
        x = am * bd;
        y = bm * ad;
        yn = (it.mode == MODE_SUB) ? !bn : bn;
        if (an == yn) begin
          num = x + y; neg = an;
        end else if (x >= y) begin
          num = x - y; neg = an;
        end else begin
          num = y - x; neg = yn;
        end
        den = ad * bd;
      end
      MODE_MUL: begin
        num = am * bm; den = ad * bd; neg = an ^ bn;
      end
      default: begin
        num = am * bd; den = ad * bm; neg = an ^ bn;
      end
    endcase
    if (num == 0) return r;
    u = num;
    v = den;
    while (v != 0) begin
      t = u % v; u = v; v = t;
    end
    num = num / u;
    den = den / u;
    if (den > ((128'(1) << (WIDTH-1)) - 128'(1)) ||
        num > (neg ? (128'(1) << (WIDTH-1)) : ((128'(1) << (WIDTH-1)) - 128'(1)))) begin
      r.status = ST_OVFL;
      return r;
    end
    r.res_num = neg ? -num[WIDTH-1:0] : num[WIDTH-1:0];
    r.res_den = den[WIDTH-2:0];
    return r;
  endfunction

  class fraction_scoreboard;
    out_item_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_item(in_item_t it);
      pending.push_back(reduce_fraction(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no item waiting: %0d/%0d st %0d", got.res_num, got.res_den,
               got.status);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.res_num !== exp_r.res_num) begin
        $error("res_num expected %0d actual %0d", exp_r.res_num, got.res_num);
        errors++;
      end
      if (got.res_den !== exp_r.res_den) begin
        $error("res_den expected %0d actual %0d", exp_r.res_den, got.res_den);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status expected %0d actual %0d", exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  fraction_scoreboard sb = new();
  bit quiet_tail = 0;
  bit hold_off = 0;
  int stall_left = 0;
  int unsigned cycles = 0;

  rational_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else if (!quiet_tail && stall_left > 0) begin
      out_ready <= 0;
      stall_left <= stall_left - 1;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      out_ready <= 0;
      stall_left <= $urandom_range(0, 5);
    end else out_ready <= 1;
  end

  function automatic logic [WIDTH-1:0] pick_num();
    case ($urandom_range(0, 5))
      0: return WIDTH'($urandom_range(0, 20)) - 10;
      1: return {1'b1, {(WIDTH-1){1'b0}}};
      2: return {1'b0, {(WIDTH-1){1'b1}}};
      3: return WIDTH'($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WIDTH-2:0] pick_den();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return {(WIDTH-1){1'b1}};
      2: return (WIDTH-1)'($urandom_range(1, 12));
      3: return (WIDTH-1)'($urandom_range(1, 5000));
      default: return (WIDTH-1)'($urandom);
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [1:0] m, logic [WIDTH-1:0] an, logic [WIDTH-2:0] ad,
                             logic [WIDTH-1:0] bn, logic [WIDTH-2:0] bd);
    in_item_t it;
    it.mode = m; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
    send_item(it);
  endtask

  task automatic send_random();
    in_item_t it;
    it.mode = 2'($urandom_range(0, 3));
    it.a_num = pick_num();
    it.a_den = pick_den();
    it.b_num = $urandom_range(0, 9) == 0 ? '0 : pick_num();
    it.b_den = pick_den();
    send_item(it);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    @(negedge clk);
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  localparam logic [WIDTH-1:0] NMIN = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] NMAX = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic [WIDTH-2:0] DMAX = {(WIDTH-1){1'b1}};

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_fields(MODE_ADD, 1, 2, 1, 3);
    send_fields(MODE_SUB, 1, 2, 1, 2);
    send_fields(MODE_MUL, 3, 4, -4, 3);
    send_fields(MODE_DIV, 1, 2, 1, 4);
    send_fields(MODE_ADD, 5, 0, 1, 3);
    send_fields(MODE_SUB, 5, 7, 1, 0);
    send_fields(MODE_DIV, 5, 7, 0, 3);
    send_fields(MODE_MUL, 0, 7, 9, 3);
    send_fields(MODE_ADD, 6, 4, 2, 4);
    send_fields(MODE_ADD, NMAX, 1, NMAX, 1);
    send_fields(MODE_SUB, NMIN, 1, 1, 1);
    send_fields(MODE_MUL, NMIN, 1, -1, 1);
    send_fields(MODE_MUL, NMIN, 1, 1, 1);
    send_fields(MODE_DIV, NMIN, 1, NMIN, 1);
    send_fields(MODE_MUL, 1, DMAX, 1, DMAX);
    send_fields(MODE_ADD, NMAX, DMAX, NMIN, DMAX);
    send_fields(MODE_DIV, -1, DMAX, NMAX, 1);
    send_fields(MODE_SUB, -3, 5, -3, 5);
    for (int i = 0; i < 320; i++) send_random();
    hold_off = 1;
    fork
      begin
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) send_random();
    join
    drain();
    for (int i = 0; i < 250; i++) send_random();
    drain();
    quiet_tail = 1;
    for (int i = 0; i < 60; i++) send_random();
    drain();
    repeat (1000) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

FILE: rational_arithmetic_unit.f
rtl/core/rau_pkg.sv
rtl/core/rau_alu.sv
rtl/core/rational_arithmetic_unit.sv
bench/tb_rational_arithmetic_unit.sv
